// ----- hdl/fph_pkg.sv -----
// Package for the fit-policy hole allocator: field widths, policy and
// register codes, and the command type passed from front end to engine.
// No dependencies.
`timescale 1ns / 1ps

package fph_pkg;

  localparam int HOLES_DEF = 16;
  localparam int QDEPTH    = 2;

  localparam int IDX_W  = 4;
  localparam int SIZE_W = 16;
  localparam int HC_W   = 5;
  localparam int POL_W  = 2;
  localparam int CFG_W  = 5;

  // placement rules; the unused code behaves as first fit
  localparam logic [POL_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [POL_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [POL_W-1:0] FIT_WORST = 2'd2;

  // configuration register indexes
  localparam logic REG_FIT_POLICY = 1'b0;
  localparam logic REG_HOLE_COUNT = 1'b1;

  // input kinds
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef struct packed {
    logic              op;
    logic [IDX_W-1:0]  tgt;
    logic [SIZE_W-1:0] size;
  } cmd_t;

endpackage

// ----- hdl/fph_queue.sv -----
// Small command FIFO between the front end and the scan engine.
// Depends on fph_pkg (cmd_t).
`timescale 1ns / 1ps

module fph_queue #(
  parameter int DEPTH = fph_pkg::QDEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fph_pkg::cmd_t push_cmd,
  output logic          push_ready,
  input  logic          pop,
  output logic          head_valid,
  output fph_pkg::cmd_t head_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  fph_pkg::cmd_t    entry_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count exceeds depth");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_pop && !do_push) |=> (count_r == $past(count_r) - 1'b1))
    else $error("queue count did not drop on pop");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not rise on push");
`endif

endmodule

// ----- hdl/fph_front.sv -----
// Input stage: takes stream transfers, drops loads aimed past the table,
// and holds the decoded command until the queue takes it.
// Depends on fph_pkg.
`timescale 1ns / 1ps

module fph_front #(
  parameter int HOLES = fph_pkg::HOLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_op,
  input  logic [fph_pkg::IDX_W-1:0]   in_tgt,
  input  logic [fph_pkg::SIZE_W-1:0]  in_size,
  output logic                        cmd_valid,
  output fph_pkg::cmd_t               cmd,
  input  logic                        cmd_ready
);

  localparam logic [8:0] HOLES_W = 9'(HOLES);

  logic          hold_r, hold_nxt;
  fph_pkg::cmd_t cmd_r;
  logic          take;
  logic          keep;

  assign in_ready  = !hold_r || cmd_ready;
  assign take      = in_valid && in_ready;
  // a load past the table end is a no-op: never enters the queue
  assign keep      = (in_op == fph_pkg::OP_ALLOC) || ({5'd0, in_tgt} < HOLES_W);
  assign cmd_valid = hold_r;
  assign cmd       = cmd_r;

  always_comb begin
    hold_nxt = hold_r;
    if (hold_r && cmd_ready) begin
      hold_nxt = 1'b0;
    end
    if (take && keep) begin
      hold_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && keep) begin
      cmd_r.op   <= in_op;
      cmd_r.tgt  <= in_tgt;
      cmd_r.size <= in_size;
    end
  end

endmodule

// ----- hdl/fph_engine.sv -----
// Scan engine: hole size memory with valid bits, one-entry-per-cycle scan
// under the fit policy, update of the chosen hole, and the result register.
// Depends on fph_pkg.
`timescale 1ns / 1ps

module fph_engine #(
  parameter int HOLES = fph_pkg::HOLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [fph_pkg::POL_W-1:0]   fit_policy,
  input  logic [fph_pkg::HC_W-1:0]    hole_count,
  input  logic                        q_valid,
  input  fph_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_granted,
  output logic [fph_pkg::IDX_W-1:0]   out_hole,
  output logic [fph_pkg::SIZE_W-1:0]  out_remain
);

  localparam int IW = (HOLES > 1) ? $clog2(HOLES) : 1;
  localparam int CW = $clog2(HOLES + 1);
  localparam int LW = (CW > fph_pkg::HC_W) ? CW : fph_pkg::HC_W;
  localparam int SW = fph_pkg::SIZE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;

  logic [1:0]     state_r, state_nxt;

  logic [SW-1:0]  mem [HOLES];
  logic [HOLES-1:0] vld_r;
  logic [SW-1:0]  rd_r;
  logic           rd_vld_r;

  logic           we;
  logic [IW-1:0]  waddr;
  logic [SW-1:0]  wdata;
  logic [IW-1:0]  raddr;

  logic [LW-1:0]  cnt_r, act_r;
  logic [LW-1:0]  active;
  logic [SW-1:0]  sz_r;
  logic           pend_r;
  logic [IW-1:0]  pidx_r;
  logic           found_r;
  logic [SW-1:0]  best_r;
  logic [IW-1:0]  pick_r;

  logic           out_valid_r;
  logic           out_granted_r;
  logic [fph_pkg::IDX_W-1:0] out_hole_r;
  logic [SW-1:0]  out_remain_r;

  logic           issue;
  logic [SW-1:0]  h;
  logic           fits;
  logic           take;
  logic           out_free;
  logic [LW-1:0]  hc_ext, holes_ext;

  assign hc_ext    = LW'(hole_count);
  assign holes_ext = LW'(HOLES);
  assign active    = (hc_ext > holes_ext) ? holes_ext : hc_ext;

  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == S_IDLE) && q_valid;
  assign issue    = (state_r == S_SCAN) && (cnt_r < act_r);
  assign raddr    = cnt_r[IW-1:0];

  // entries never loaded read as zero
  assign h    = rd_vld_r ? rd_r : '0;
  assign fits = (sz_r <= h);

  always_comb begin
    take = 1'b0;
    if (pend_r && fits) begin
      case (fit_policy)
        fph_pkg::FIT_BEST:  take = !found_r || (h < best_r);
        fph_pkg::FIT_WORST: take = !found_r || (h >= best_r);
        default:            take = !found_r;
      endcase
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = pick_r;
    wdata = best_r - sz_r;
    if (q_pop && (q_cmd.op == fph_pkg::OP_LOAD)) begin
      we    = 1'b1;
      waddr = IW'(q_cmd.tgt);
      wdata = q_cmd.size;
    end else if ((state_r == S_UPD) && found_r && out_free) begin
      we = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid && (q_cmd.op == fph_pkg::OP_ALLOC)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!issue && !pend_r) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= vld_r[raddr];
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      pend_r <= issue;
      if (q_pop && (q_cmd.op == fph_pkg::OP_ALLOC)) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
      if ((state_r == S_UPD) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && (q_cmd.op == fph_pkg::OP_ALLOC)) begin
      sz_r  <= q_cmd.size;
      cnt_r <= '0;
      act_r <= active;
    end else if (issue) begin
      cnt_r <= cnt_r + 1'b1;
    end
    pidx_r <= raddr;
    if (take) begin
      best_r <= h;
      pick_r <= pidx_r;
    end
    if ((state_r == S_UPD) && out_free) begin
      out_granted_r <= found_r;
      out_hole_r    <= found_r ? fph_pkg::IDX_W'(pick_r) : '0;
      out_remain_r  <= found_r ? (best_r - sz_r) : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_granted = out_granted_r;
  assign out_hole    = out_hole_r;
  assign out_remain  = out_remain_r;

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (cnt_r <= act_r))
    else $error("scan counter ran past active hole count");
  a_pick_active: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_UPD) && found_r) |-> (LW'(pick_r) < act_r))
    else $error("chosen hole outside the active range");
  a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_UPD) && found_r) |-> (best_r >= sz_r))
    else $error("chosen hole smaller than request");
  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_SCAN))
    else $error("read pending outside scan");
`endif

endmodule

// ----- hdl/fit_policy_hole_allocator_top.sv -----
// Allocate item: the engine pops it, reads memory once per active hole, drains the last
// compare, then updates; a load item is written into the table as it is popped.
// One item in the engine at a time; a 2-entry queue and the input stage keep
// accepting while the engine scans or a result waits in the output register.
// Synchronous active-low reset: hole table reads as all zero via valid bits,
// fit_policy = first fit, hole_count = 16, queues and output empty.
`timescale 1ns / 1ps

module fit_policy_hole_allocator_top #(
  parameter int HOLES = fph_pkg::HOLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // [3:0] target_hole, [19:4] size_value
  input  logic                        in_tuser,   // [0] op
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // [3:0] chosen_hole, [19:4] remaining_size
  output logic                        out_tuser,  // [0] granted
  input  logic                        cfg_wr_en,
  input  logic                        cfg_index,
  input  logic [fph_pkg::CFG_W-1:0]   cfg_wdata
);

  logic [fph_pkg::POL_W-1:0]  fit_policy_r;
  logic [fph_pkg::HC_W-1:0]   hole_count_r;

  logic                       f_valid, f_ready;
  fph_pkg::cmd_t              f_cmd;
  logic                       q_valid, q_pop;
  fph_pkg::cmd_t              q_cmd;
  logic [fph_pkg::IDX_W-1:0]  res_hole;
  logic [fph_pkg::SIZE_W-1:0] res_remain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= fph_pkg::FIT_FIRST;
      hole_count_r <= fph_pkg::HC_W'(16);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fph_pkg::REG_FIT_POLICY: fit_policy_r <= cfg_wdata[fph_pkg::POL_W-1:0];
        fph_pkg::REG_HOLE_COUNT: hole_count_r <= cfg_wdata[fph_pkg::HC_W-1:0];
        default: ;
      endcase
    end
  end

  fph_front #(.HOLES(HOLES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_tgt    (in_tdata[3:0]),
    .in_size   (in_tdata[19:4]),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  fph_queue #(.DEPTH(fph_pkg::QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (f_valid),
    .push_cmd   (f_cmd),
    .push_ready (f_ready),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_cmd)
  );

  fph_engine #(.HOLES(HOLES)) u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .fit_policy  (fit_policy_r),
    .hole_count  (hole_count_r),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_granted (out_tuser),
    .out_hole    (res_hole),
    .out_remain  (res_remain)
  );

  assign out_tdata = {4'd0, res_remain, res_hole};

endmodule

// ----- test/tb_fit_policy_hole_allocator_top.sv -----
// Testbench for fit_policy_hole_allocator_top: loads hole sizes, issues allocations
// under every placement rule and hole counts 0, 1, 16, 31 and random ones in 1..16,
// and checks each grant against a local model. Depends on fph_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_fit_policy_hole_allocator_top;

  localparam logic [fph_pkg::POL_W-1:0] FIT_SPARE = 2'd3;  // unused code, acts as first fit
  localparam int SETTLE_CYCLES = 40;
  localparam int IDLE_LIMIT    = 5000;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 148;

  typedef struct packed {
    logic                       granted;
    logic [fph_pkg::IDX_W-1:0]  hole;
    logic [fph_pkg::SIZE_W-1:0] rest;
  } grant_t;

  // Hole table model plus the queue of grants still owed by the block.
  class alloc_scoreboard;
    logic [fph_pkg::SIZE_W-1:0] hole_size [fph_pkg::HOLES_DEF];
    logic [fph_pkg::POL_W-1:0]  policy;
    logic [fph_pkg::HC_W-1:0]   count;
    grant_t            awaited[$];
    int errors, checked, grants, refusals, loads, allocs;

    function new();
      foreach (hole_size[i]) hole_size[i] = '0;
      policy = fph_pkg::FIT_FIRST;
      count  = 5'd16;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function void write_reg(logic idx, logic [fph_pkg::HC_W-1:0] val);
      if (idx == fph_pkg::REG_FIT_POLICY) policy = val[fph_pkg::POL_W-1:0];
      else count = val;
    endfunction

    function void note_item(logic op, logic [fph_pkg::IDX_W-1:0] tgt,
                            logic [fph_pkg::SIZE_W-1:0] sz);
      grant_t g;
      int active;
      int pick;
      bit found;
      if (op == fph_pkg::OP_LOAD) begin
        hole_size[tgt] = sz;
        loads++;
        return;
      end
      allocs++;
      active = (int'(count) > fph_pkg::HOLES_DEF) ? fph_pkg::HOLES_DEF : int'(count);
      pick = 0;
      found = 0;
      for (int j = 0; j < active; j++) begin
        if (sz > hole_size[j]) continue;
        if (policy == fph_pkg::FIT_BEST) begin
          if (!found || hole_size[j] < hole_size[pick]) begin
            pick = j;
            found = 1;
          end
        end else if (policy == fph_pkg::FIT_WORST) begin
          // >= so the last of equal largest holes wins
          if (!found || hole_size[j] >= hole_size[pick]) begin
            pick = j;
            found = 1;
          end
        end else begin
          pick = j;
          found = 1;
          break;
        end
      end
      if (found) begin
        hole_size[pick] = hole_size[pick] - sz;
        g.granted = 1'b1;
        g.hole    = pick[fph_pkg::IDX_W-1:0];
        g.rest    = hole_size[pick];
        grants++;
      end else begin
        g = '0;
        refusals++;
      end
      awaited.push_back(g);
    endfunction

    function void check_result(grant_t got);
      grant_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("result with nothing pending: granted=%0d hole=%0d size=%0d",
                       got.granted, got.hole, got.rest));
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.granted !== want.granted || got.hole !== want.hole || got.rest !== want.rest)
        flag($sformatf("result %0d: expected granted=%0d hole=%0d size=%0d, got %0d/%0d/%0d",
                       checked, want.granted, want.hole, want.rest,
                       got.granted, got.hole, got.rest));
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void close_out();
      if (awaited.size() != 0)
        flag($sformatf("%0d results never arrived", awaited.size()));
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [23:0]                in_tdata = '0;
  logic                       in_tuser = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [23:0]                out_tdata;
  logic                       out_tuser;
  logic                       cfg_wr_en = 1'b0;
  logic                       cfg_index = 1'b0;
  logic [fph_pkg::CFG_W-1:0]  cfg_wdata = '0;

  alloc_scoreboard book = new();
  bit tx_eager = 0;
  bit rx_eager = 0;
  int hold_req = 0;
  int cfg_writes = 0;

  always #5 clk = ~clk;

  fit_policy_hole_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // result side: random stalls, plus a long forced hold on request
  initial begin
    int stall_left;
    grant_t got;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        got.granted = out_tuser;
        got.hole    = out_tdata[3:0];
        got.rest    = out_tdata[19:4];
        book.check_result(got);
      end
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (rx_eager) begin
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // no transfer on either side for too long means the block hung
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d results pending",
                 idle_cycles, book.pending());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic int tx_gap();
    if (tx_eager || $urandom_range(0, 3) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // valid stays high across back-to-back items; lowered only for a gap
  task automatic send_item(logic op, logic [fph_pkg::IDX_W-1:0] tgt,
                           logic [fph_pkg::SIZE_W-1:0] sz);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, sz, tgt};
    do @(posedge clk); while (!in_tready);
    book.note_item(op, tgt, sz);
  endtask

  // loads leave no result, so give the engine time after the last grant
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_wr_en is dropped again before the task returns, so back-to-back writes stay apart
  task automatic write_reg(logic idx, logic [fph_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    book.write_reg(idx, val);
    cfg_writes++;
    @(posedge clk);
  endtask

  function automatic logic [fph_pkg::SIZE_W-1:0] load_size();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 16)) << 4;
      default: return 16'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic logic [fph_pkg::SIZE_W-1:0] request_size();
    case ($urandom_range(0, 6))
      0: return 16'($urandom);
      1: return book.hole_size[$urandom_range(0, fph_pkg::HOLES_DEF - 1)];  // exact fit
      2: return 16'($urandom_range(0, 8)) << 4;
      3: return 16'd0;
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  initial begin
    logic [fph_pkg::POL_W-1:0] pol;
    logic [fph_pkg::CFG_W-1:0] cnt;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: table starts cleared, first fit over 16 holes
    tx_eager = 1;
    send_item(fph_pkg::OP_ALLOC, 4'd9, 16'd0);      // zero request fits an empty hole
    send_item(fph_pkg::OP_ALLOC, 4'd0, 16'd1);      // nothing free yet
    send_item(fph_pkg::OP_LOAD, 4'd0, 16'hFFFF);
    send_item(fph_pkg::OP_LOAD, 4'd15, 16'h8000);
    send_item(fph_pkg::OP_LOAD, 4'd5, 16'd100);
    send_item(fph_pkg::OP_LOAD, 4'd7, 16'd100);
    send_item(fph_pkg::OP_LOAD, 4'd9, 16'd300);
    send_item(fph_pkg::OP_ALLOC, 4'd0, 16'hFFFF);   // drains hole 0 completely
    send_item(fph_pkg::OP_ALLOC, 4'd15, 16'd50);
    settle();
    write_reg(fph_pkg::REG_FIT_POLICY, fph_pkg::CFG_W'(fph_pkg::FIT_BEST));
    send_item(fph_pkg::OP_LOAD, 4'd3, 16'd40);
    send_item(fph_pkg::OP_LOAD, 4'd11, 16'd40);
    send_item(fph_pkg::OP_ALLOC, 4'd0, 16'd40);     // tie, lower index wins
    send_item(fph_pkg::OP_ALLOC, 4'd0, 16'd60);
    settle();
    write_reg(fph_pkg::REG_FIT_POLICY, fph_pkg::CFG_W'(fph_pkg::FIT_WORST));
    send_item(fph_pkg::OP_LOAD, 4'd4, 16'h9000);
    send_item(fph_pkg::OP_LOAD, 4'd14, 16'h9000);
    send_item(fph_pkg::OP_ALLOC, 4'd0, 16'h1000);   // tie, higher index wins
    settle();
    write_reg(fph_pkg::REG_FIT_POLICY, fph_pkg::CFG_W'(FIT_SPARE));
    send_item(fph_pkg::OP_ALLOC, 4'd0, 16'd1);
    settle();
    write_reg(fph_pkg::REG_HOLE_COUNT, 5'd0);       // every request refused
    send_item(fph_pkg::OP_ALLOC, 4'd0, 16'd0);
    settle();
    write_reg(fph_pkg::REG_HOLE_COUNT, 5'd31);      // saturates to all holes
    send_item(fph_pkg::OP_ALLOC, 4'd0, 16'h8000);
    settle();
    write_reg(fph_pkg::REG_HOLE_COUNT, 5'd1);
    send_item(fph_pkg::OP_LOAD, 4'd8, 16'hFFFF);    // stored while inactive
    send_item(fph_pkg::OP_ALLOC, 4'd0, 16'hF000);
    settle();
    write_reg(fph_pkg::REG_FIT_POLICY, fph_pkg::CFG_W'(fph_pkg::FIT_FIRST));
    write_reg(fph_pkg::REG_HOLE_COUNT, 5'd16);
    send_item(fph_pkg::OP_ALLOC, 4'd0, 16'hF000);   // hole 8 now visible
    settle();

    // random phases, each under its own register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin pol = fph_pkg::FIT_FIRST; cnt = 5'd16; end
        1: begin pol = fph_pkg::FIT_BEST;  cnt = 5'd31; end
        2: begin pol = fph_pkg::FIT_WORST; cnt = 5'd1;  end
        3: begin pol = FIT_SPARE; cnt = 5'd0;  end
        default: begin
          pol = fph_pkg::POL_W'($urandom_range(0, 2));
          cnt = ($urandom_range(0, 4) == 0) ? 5'd31 :
                fph_pkg::CFG_W'($urandom_range(1, 16));
        end
      endcase
      write_reg(fph_pkg::REG_FIT_POLICY, fph_pkg::CFG_W'(pol));
      write_reg(fph_pkg::REG_HOLE_COUNT, cnt);
      tx_eager = (ph % 3 == 2);
      rx_eager = (ph % 3 == 2);
      if (ph == 1) hold_req = 400;         // back up the output until input stalls
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 9) < 4)
          send_item(fph_pkg::OP_LOAD, fph_pkg::IDX_W'($urandom_range(0, 15)), load_size());
        else
          send_item(fph_pkg::OP_ALLOC, fph_pkg::IDX_W'($urandom_range(0, 15)),
                    request_size());
      end
      settle();
    end

    book.close_out();
    $display("%0d loads and %0d allocations (%0d granted, %0d refused), %0d register writes",
             book.loads, book.allocs, book.grants, book.refusals, cfg_writes);
    $display("all three placement rules plus the spare code, hole counts 0, 1, 16 and 31");
    if (book.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d errors", book.errors);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
